>>> sv/bts_pkg.sv
package bts_pkg;

	localparam int STORE_BYTES  = 262144;
	localparam int ADDR_BITS    = $clog2(STORE_BYTES);
	localparam int FRAC_BITS    = 16;
	localparam int SIZE_BITS    = 11;
	localparam int BPT_BITS     = 3;
	localparam int CHAN_BITS    = 16;
	localparam int NUM_CH       = 3;
	localparam int WEIGHT_BITS  = FRAC_BITS + 1;
	localparam int SCALED_BITS  = FRAC_BITS + SIZE_BITS;
	localparam int WPROD_BITS   = 2 * FRAC_BITS + 1;
	localparam int SUM_BITS     = 2 * FRAC_BITS + 8;
	localparam int RESULT_SHIFT = 2 * FRAC_BITS - 8;
	localparam int SEQ_BITS     = 4;

	localparam logic [SEQ_BITS-1:0]    SEQ_LAST   = SEQ_BITS'(4 * NUM_CH - 1);
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROW_STRIDE = 2'd2;
	localparam logic [1:0] REG_BPT        = 2'd3;

	typedef struct packed {
		logic                      is_write;
		logic [3:0][ADDR_BITS-1:0] base;
		logic [FRAC_BITS-1:0]      wa;
		logic [FRAC_BITS-1:0]      wb;
		logic [ADDR_BITS-1:0]      waddr;
		logic [7:0]                wdata;
	} fetch_req_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} rgb_t;

endpackage

>>> sv/bts_fetch.sv
module bts_fetch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bts_pkg::fetch_req_t req,
	output logic              res_valid,
	input  logic              res_stall,
	output bts_pkg::rgb_t     res
);

	logic [7:0] store_mem [bts_pkg::STORE_BYTES];

	logic                          busy_q;
	logic [bts_pkg::SEQ_BITS-1:0]  cnt_q;
	bts_pkg::fetch_req_t           cur_q;
	logic                          out_valid_q;
	bts_pkg::rgb_t                 out_q;

	logic                          v_s8;
	logic [7:0]                    rd_s8;
	logic [bts_pkg::WPROD_BITS-1:0] w_s8;
	logic [1:0]                    ch_s8;
	logic                          first_s8;
	logic                          last_s8;

	logic                          v_s9;
	logic [bts_pkg::SUM_BITS-1:0]  prod_s9;
	logic [1:0]                    ch_s9;
	logic                          first_s9;
	logic                          last_s9;

	logic [bts_pkg::SUM_BITS-1:0]  acc_q [bts_pkg::NUM_CH];

	logic                            run;
	logic                            last;
	logic                            take;
	logic                            rd_en;
	logic                            wr_en;
	logic [1:0]                      ch;
	logic [1:0]                      tx;
	logic [bts_pkg::ADDR_BITS-1:0]   rd_addr;
	logic [bts_pkg::WEIGHT_BITS-1:0] wx;
	logic [bts_pkg::WEIGHT_BITS-1:0] wy;
	logic [2*bts_pkg::WEIGHT_BITS-1:0] wfull;
	logic [bts_pkg::WPROD_BITS+7:0]  pfull;
	logic [bts_pkg::SUM_BITS-1:0]    blue_sum;

	assign run       = !(out_valid_q && res_stall && v_s9 && last_s9);
	assign last      = (cnt_q == bts_pkg::SEQ_LAST);
	assign req_ready = run && (!busy_q || last);
	assign take      = req_valid && req_ready;
	assign rd_en     = run && busy_q && !cur_q.is_write;
	assign wr_en     = run && busy_q && cur_q.is_write;

	assign ch      = cnt_q[3:2];
	assign tx      = cnt_q[1:0];
	assign rd_addr = cur_q.base[tx] + bts_pkg::ADDR_BITS'(ch);

	assign wx    = tx[0] ? {1'b0, cur_q.wa} : bts_pkg::WEIGHT_ONE - {1'b0, cur_q.wa};
	assign wy    = tx[1] ? {1'b0, cur_q.wb} : bts_pkg::WEIGHT_ONE - {1'b0, cur_q.wb};
	assign wfull = wx * wy;
	assign pfull = rd_s8 * w_s8;

	assign blue_sum = acc_q[2] + prod_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (run) begin
				if (take) begin
					busy_q <= 1'b1;
					cnt_q  <= req.is_write ? bts_pkg::SEQ_LAST : '0;
				end else if (busy_q) begin
					if (last) begin
						busy_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				v_s8 <= rd_en;
				v_s9 <= v_s8;
			end
			if (run && v_s9 && last_s9) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= req;
		end
		if (wr_en) begin
			store_mem[cur_q.waddr] <= cur_q.wdata;
		end
		if (rd_en) begin
			rd_s8 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			w_s8     <= wfull[bts_pkg::WPROD_BITS-1:0];
			ch_s8    <= ch;
			first_s8 <= (tx == 2'd0);
			last_s8  <= last;
			prod_s9  <= pfull[bts_pkg::SUM_BITS-1:0];
			ch_s9    <= ch_s8;
			first_s9 <= first_s8;
			last_s9  <= last_s8;
			if (v_s9) begin
				acc_q[ch_s9] <= first_s9 ? prod_s9 : acc_q[ch_s9] + prod_s9;
			end
			if (v_s9 && last_s9) begin
				out_q.red   <= acc_q[0][bts_pkg::RESULT_SHIFT +: bts_pkg::CHAN_BITS];
				out_q.green <= acc_q[1][bts_pkg::RESULT_SHIFT +: bts_pkg::CHAN_BITS];
				out_q.blue  <= blue_sum[bts_pkg::RESULT_SHIFT +: bts_pkg::CHAN_BITS];
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> sv/bilinear_texture_sampler.sv
// Channel  Handshake           Contents
// sample   sample_valid/stall  command, u_coord, v_coord, write_address, write_data
// result   result_valid/stall  red, green, blue
// cfg      cfg_valid/ready     cfg_index, cfg_data
// A write request takes a single write of the texel memory; a sample request takes
// twelve reads, one byte per cycle from the single-port texel memory while the fetch
// unit is not held, and it takes the next request only in the current one's last read.
// Reset clears the pipeline and returns the registers to their defaults; the texel
// memory keeps its contents. A stalled result holds the fetch unit only once the next
// result is ready, and the front stages keep taking requests until they fill.
module bilinear_texture_sampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic                            command,
	input  logic signed [23:0]              u_coord,
	input  logic signed [23:0]              v_coord,
	input  logic [17:0]                     write_address,
	input  logic [7:0]                      write_data,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [bts_pkg::CHAN_BITS-1:0]   red,
	output logic [bts_pkg::CHAN_BITS-1:0]   green,
	output logic [bts_pkg::CHAN_BITS-1:0]   blue,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [bts_pkg::SIZE_BITS-1:0]   cfg_data
);

	logic [bts_pkg::SIZE_BITS-1:0] tex_width_q;
	logic [bts_pkg::SIZE_BITS-1:0] tex_height_q;
	logic [bts_pkg::SIZE_BITS-1:0] row_stride_q;
	logic [bts_pkg::BPT_BITS-1:0]  bpt_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic [bts_pkg::ADDR_BITS-1:0] wadr_s1, wadr_s2, wadr_s3, wadr_s4, wadr_s5;
	logic [7:0]                    wdat_s1, wdat_s2, wdat_s3, wdat_s4, wdat_s5;

	logic [bts_pkg::FRAC_BITS-1:0]   uf_s1, vf_s1;
	logic [bts_pkg::SCALED_BITS-1:0] su_s2, sv_s2;
	logic [bts_pkg::SIZE_BITS-1:0]   x0_s3, x1_s3, y0_s3, y1_s3;
	logic [bts_pkg::FRAC_BITS-1:0]   a_s3, b_s3, a_s4, b_s4, a_s5, b_s5;
	logic [bts_pkg::SIZE_BITS-1:0]   x0_s4, x1_s4;
	logic [bts_pkg::ADDR_BITS-1:0]   row0_s4, row1_s4;
	logic [3:0][bts_pkg::ADDR_BITS-1:0] lin_s5;
	bts_pkg::fetch_req_t             req_s6;

	logic                            fetch_ready;
	bts_pkg::rgb_t                   res;

	logic [bts_pkg::SIZE_BITS:0]     xn, yn;
	logic [bts_pkg::SIZE_BITS-1:0]   x0_n, y0_n;
	logic [2*bts_pkg::SIZE_BITS-1:0] p0, p1;
	logic [3:0][bts_pkg::ADDR_BITS+bts_pkg::BPT_BITS-1:0] mb;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= bts_pkg::SIZE_BITS'(256);
			tex_height_q <= bts_pkg::SIZE_BITS'(256);
			row_stride_q <= bts_pkg::SIZE_BITS'(256);
			bpt_q        <= bts_pkg::BPT_BITS'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bts_pkg::REG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				bts_pkg::REG_TEX_HEIGHT: tex_height_q <= cfg_data;
				bts_pkg::REG_ROW_STRIDE: row_stride_q <= cfg_data;
				bts_pkg::REG_BPT:        bpt_q        <= cfg_data[bts_pkg::BPT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign rdy6 = !v_s6 || fetch_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign sample_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sample_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	assign x0_n = su_s2[bts_pkg::SCALED_BITS-1:bts_pkg::FRAC_BITS];
	assign y0_n = sv_s2[bts_pkg::SCALED_BITS-1:bts_pkg::FRAC_BITS];
	assign xn   = {1'b0, x0_n} + 1'b1;
	assign yn   = {1'b0, y0_n} + 1'b1;
	assign p0   = y0_s3 * row_stride_q;
	assign p1   = y1_s3 * row_stride_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mb[i] = lin_s5[i] * bpt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1  <= command;
			uf_s1   <= u_coord[bts_pkg::FRAC_BITS-1:0];
			vf_s1   <= v_coord[bts_pkg::FRAC_BITS-1:0];
			wadr_s1 <= write_address[bts_pkg::ADDR_BITS-1:0];
			wdat_s1 <= write_data;
		end
		if (rdy2) begin
			cmd_s2  <= cmd_s1;
			su_s2   <= bts_pkg::SCALED_BITS'(uf_s1) * bts_pkg::SCALED_BITS'(tex_width_q);
			sv_s2   <= bts_pkg::SCALED_BITS'(vf_s1) * bts_pkg::SCALED_BITS'(tex_height_q);
			wadr_s2 <= wadr_s1;
			wdat_s2 <= wdat_s1;
		end
		if (rdy3) begin
			cmd_s3  <= cmd_s2;
			x0_s3   <= x0_n;
			y0_s3   <= y0_n;
			x1_s3   <= (xn < {1'b0, tex_width_q}) ? xn[bts_pkg::SIZE_BITS-1:0] : x0_n;
			y1_s3   <= (yn < {1'b0, tex_height_q}) ? yn[bts_pkg::SIZE_BITS-1:0] : y0_n;
			a_s3    <= su_s2[bts_pkg::FRAC_BITS-1:0];
			b_s3    <= sv_s2[bts_pkg::FRAC_BITS-1:0];
			wadr_s3 <= wadr_s2;
			wdat_s3 <= wdat_s2;
		end
		if (rdy4) begin
			cmd_s4  <= cmd_s3;
			x0_s4   <= x0_s3;
			x1_s4   <= x1_s3;
			row0_s4 <= p0[bts_pkg::ADDR_BITS-1:0];
			row1_s4 <= p1[bts_pkg::ADDR_BITS-1:0];
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			wadr_s4 <= wadr_s3;
			wdat_s4 <= wdat_s3;
		end
		if (rdy5) begin
			cmd_s5    <= cmd_s4;
			lin_s5[0] <= bts_pkg::ADDR_BITS'(x0_s4) + row0_s4;
			lin_s5[1] <= bts_pkg::ADDR_BITS'(x1_s4) + row0_s4;
			lin_s5[2] <= bts_pkg::ADDR_BITS'(x0_s4) + row1_s4;
			lin_s5[3] <= bts_pkg::ADDR_BITS'(x1_s4) + row1_s4;
			a_s5      <= a_s4;
			b_s5      <= b_s4;
			wadr_s5   <= wadr_s4;
			wdat_s5   <= wdat_s4;
		end
		if (rdy6) begin
			req_s6.is_write <= (cmd_s5 == bts_pkg::CMD_WRITE);
			for (int i = 0; i < 4; i++) begin
				req_s6.base[i] <= mb[i][bts_pkg::ADDR_BITS-1:0];
			end
			req_s6.wa    <= a_s5;
			req_s6.wb    <= b_s5;
			req_s6.waddr <= wadr_s5;
			req_s6.wdata <= wdat_s5;
		end
	end

	bts_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s6),
		.req_ready (fetch_ready),
		.req       (req_s6),
		.res_valid (result_valid),
		.res_stall (result_stall),
		.res       (res)
	);

	assign red   = res.red;
	assign green = res.green;
	assign blue  = res.blue;

endmodule

>>> sv/bts_checker.sv
module bts_assertions (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [bts_pkg::CHAN_BITS-1:0] red,
	input logic [bts_pkg::CHAN_BITS-1:0] green,
	input logic [bts_pkg::CHAN_BITS-1:0] blue
);

	localparam logic [bts_pkg::CHAN_BITS-1:0] CHAN_MAX = 16'hFF00;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("result payload changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result request during reset");

	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> red <= CHAN_MAX && green <= CHAN_MAX && blue <= CHAN_MAX)
		else $error("blend exceeds the largest texel value");

endmodule

bind bilinear_texture_sampler bts_assertions u_bts_assertions (.*);
